// ----- rtl/mm4_pkg.sv -----
package mm4_pkg;

  // Matrix geometry
  localparam int DIM   = 4;
  localparam int DIM_W = 2;
  localparam int CELLS = DIM * DIM;
  localparam int IDX_W = 2 * DIM_W;

  // Arithmetic widths, signed Q16.16 elements
  localparam int WORD_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int PROD_W     = 2 * WORD_WIDTH;
  localparam int ACC_W      = PROD_W + DIM_W;
  localparam int ACT_W      = 2;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_WR_A    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_WR_B    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]             action;
    logic [IDX_W-1:0]             element_index;
    logic signed [WORD_WIDTH-1:0] element_value;
  } mm4_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]             product_index;
    logic signed [WORD_WIDTH-1:0] product_value;
    logic                         last_element;
  } mm4_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic             issue;
    logic             first;
    logic             last_k;
    logic [IDX_W-1:0] rd_a_addr;
    logic [IDX_W-1:0] rd_b_addr;
    logic             load_out;
    logic [IDX_W-1:0] out_index;
    logic             out_last;
  } mm4_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic sum_ready;
    logic out_free;
  } mm4_sts_t;

endpackage

// ----- rtl/mm4_ctrl.sv -----
module mm4_ctrl
  import mm4_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  mm4_in_t  in_data,
  input  mm4_sts_t sts,
  output mm4_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_WAIT  = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] elem_r, elem_nxt;
  logic [DIM_W-1:0] k_r, k_nxt;

  // Sequence loads and the per-element dot products
  always_comb begin
    state_nxt     = state_r;
    elem_nxt      = elem_r;
    k_nxt         = k_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.rd_a_addr = {elem_r[IDX_W-1:DIM_W], k_r};
    cmd.rd_b_addr = {k_r, elem_r[DIM_W-1:0]};
    cmd.out_index = elem_r;
    cmd.out_last  = (elem_r == IDX_W'(CELLS - 1));
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_data.action)
            ACT_WR_A: cmd.wr_a = 1'b1;
            ACT_WR_B: cmd.wr_b = 1'b1;
            ACT_COMPUTE: begin
              elem_nxt  = '0;
              k_nxt     = '0;
              state_nxt = ST_ISSUE;
            end
            default: ;
          endcase
        end
      end
      ST_ISSUE: begin
        cmd.issue  = 1'b1;
        cmd.first  = (k_r == '0);
        cmd.last_k = (k_r == DIM_W'(DIM - 1));
        k_nxt      = k_r + 1'b1;
        if (cmd.last_k) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (sts.sum_ready && sts.out_free) begin
          cmd.load_out = 1'b1;
          if (cmd.out_last) begin
            state_nxt = ST_IDLE;
          end else begin
            elem_nxt  = elem_r + 1'b1;
            state_nxt = ST_ISSUE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      elem_r  <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      elem_r  <= elem_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

// ----- rtl/mm4_dp.sv -----
module mm4_dp
  import mm4_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mm4_in_t  in_data,
  input  mm4_cmd_t cmd,
  output mm4_sts_t sts,
  output logic     out_valid,
  input  logic     out_ready,
  output mm4_out_t out_data
);

  localparam int SAT_W = ACC_W - (FRAC_BITS + WORD_WIDTH - 1);

  logic signed [WORD_WIDTH-1:0] mem_a [CELLS];
  logic signed [WORD_WIDTH-1:0] mem_b [CELLS];

  logic signed [WORD_WIDTH-1:0] a_rd_r, b_rd_r;
  logic                         rd_vld_r, rd_first_r, rd_last_r;
  logic signed [PROD_W-1:0]     prod_r;
  logic                         prod_vld_r, prod_first_r, prod_last_r;
  logic signed [ACC_W-1:0]      acc_r, prod_ext;
  logic                         sum_ready_r;
  logic                         out_valid_r;
  mm4_out_t                     out_data_r;

  logic                         acc_sign, acc_ovf;
  logic signed [WORD_WIDTH-1:0] sat_value;

  // Write one element of A or B per transfer
  always_ff @(posedge clk) begin
    if (cmd.wr_a) begin
      mem_a[in_data.element_index] <= in_data.element_value;
    end
    if (cmd.wr_b) begin
      mem_b[in_data.element_index] <= in_data.element_value;
    end
  end

  // Read one row term and one column term per issue
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      a_rd_r <= mem_a[cmd.rd_a_addr];
      b_rd_r <= mem_b[cmd.rd_b_addr];
    end
    rd_first_r   <= cmd.first;
    rd_last_r    <= cmd.last_k;
    prod_r       <= a_rd_r * b_rd_r;
    prod_first_r <= rd_first_r;
    prod_last_r  <= rd_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      prod_vld_r <= 1'b0;
    end else begin
      rd_vld_r   <= cmd.issue;
      prod_vld_r <= rd_vld_r;
    end
  end

  // Accumulate the exact products
  assign prod_ext = {{(ACC_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_ff @(posedge clk) begin
    if (prod_vld_r) begin
      acc_r <= prod_first_r ? prod_ext : acc_r + prod_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_ready_r <= 1'b0;
    end else if (prod_vld_r && prod_last_r) begin
      sum_ready_r <= 1'b1;
    end else if (cmd.load_out) begin
      sum_ready_r <= 1'b0;
    end
  end

  // Drop the fraction bits and clamp to the element range
  assign acc_sign  = acc_r[ACC_W-1];
  assign acc_ovf   = (acc_r[ACC_W-1:FRAC_BITS+WORD_WIDTH-1] != {SAT_W{acc_sign}});
  assign sat_value = !acc_ovf ? acc_r[FRAC_BITS+WORD_WIDTH-1:FRAC_BITS] :
                     acc_sign ? {1'b1, {(WORD_WIDTH-1){1'b0}}} :
                                {1'b0, {(WORD_WIDTH-1){1'b1}}};

  // Output register, held until the transfer
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.product_index <= cmd.out_index;
      out_data_r.product_value <= sat_value;
      out_data_r.last_element  <= cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign sts.sum_ready = sum_ready_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  // Result loads only from a finished sum into a free slot
  a_load_needs_sum: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sum_ready_r)
    else $error("result loaded before its sum was complete");

  a_load_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending result");

  a_last_term_done: assert property (@(posedge clk) disable iff (!rst_n)
    (prod_vld_r && prod_last_r) |=> sum_ready_r)
    else $error("final term accumulated without flagging the sum");

  a_issue_reaches_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.issue && cmd.last_k) |=> ##1 (prod_vld_r && prod_last_r))
    else $error("issued term lost in the multiply pipeline");

endmodule

// ----- rtl/matrix_multiply_4x4_top.sv -----
// 4x4 signed Q16.16 matrix multiplier.
// Input channel (in_valid/in_ready/in_data) carries one action per transfer:
// write one element of A, write one element of B, or compute. A write yields
// no result; an unused action is taken and dropped.
// A compute transfer emits the 16 elements of A times B on the result channel
// (out_valid/out_ready/out_data) in row-major order, last_element set on the
// final one. Each element is the exact sum of four 64-bit products, shifted
// right by 16 and saturated to 32 bits.
// Each element takes four reads through one read port per matrix; the read,
// multiply and accumulate registers drain before the output register loads.
// The input channel is ready only while no compute is running; it reopens
// as soon as the last element sits in the output register.
// When the receiver stalls, the held result stays put and the sequencer
// waits before loading the next one; nothing is dropped.
// Reset (rst_n low, synchronous) clears control state only; matrix contents
// are undefined until written, so load every element before computing.
module matrix_multiply_4x4_top
  import mm4_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  mm4_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output mm4_out_t out_data
);

  mm4_cmd_t cmd;
  mm4_sts_t sts;

  mm4_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .sts      (sts),
    .cmd      (cmd)
  );

  mm4_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- verif/tb_matrix_multiply_4x4_top.sv -----
module tb_matrix_multiply_4x4_top;
  import mm4_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  localparam logic signed [WORD_WIDTH-1:0] ELEM_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_WIDTH-1:0] ELEM_MIN  = 32'sh8000_0000;
  localparam logic signed [WORD_WIDTH-1:0] Q_ONE     = 32'sh0001_0000;
  localparam logic signed [WORD_WIDTH-1:0] Q_ONE_P5  = 32'sh0001_8000;
  localparam logic signed [WORD_WIDTH-1:0] Q_NEG_P5  = 32'shFFFF_8000;
  localparam logic signed [WORD_WIDTH-1:0] Q_NEG_LSB = 32'shFFFF_FFFF;

  localparam int RANDOM_ITEMS = 300;
  localparam int IDLE_PCT     = 13;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 200000;

  // Predict product elements and check the result channel against them
  class mm4_scoreboard;
    logic signed [WORD_WIDTH-1:0] left_cells[CELLS];
    logic signed [WORD_WIDTH-1:0] right_cells[CELLS];
    mm4_out_t                     pending_products[$];
    int unsigned                  mismatches;

    function new();
      foreach (left_cells[i]) begin
        left_cells[i]  = '0;
        right_cells[i] = '0;
      end
      mismatches = 0;
    endfunction

    // Exact dot product, floor shift by the fraction bits, then saturate
    function logic signed [WORD_WIDTH-1:0] product_element(int row, int col);
      logic signed [ACC_W-1:0]  acc;
      logic signed [PROD_W-1:0] prod;
      logic signed [ACC_W-1:0]  scaled;
      logic signed [ACC_W-1:0]  hi_lim;
      logic signed [ACC_W-1:0]  lo_lim;
      acc    = '0;
      hi_lim = ELEM_MAX;
      lo_lim = ELEM_MIN;
      for (int k = 0; k < DIM; k++) begin
        prod = left_cells[row*DIM + k] * right_cells[k*DIM + col];
        acc  = acc + prod;
      end
      scaled = acc >>> FRAC_BITS;
      if (scaled > hi_lim) return ELEM_MAX;
      if (scaled < lo_lim) return ELEM_MIN;
      return scaled[WORD_WIDTH-1:0];
    endfunction

    // Update the matrices, or queue all product elements on a compute
    function void note_input(mm4_in_t item);
      mm4_out_t elem;
      case (item.action)
        ACT_WR_A: left_cells[item.element_index] = item.element_value;
        ACT_WR_B: right_cells[item.element_index] = item.element_value;
        ACT_COMPUTE: begin
          for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < DIM; c++) begin
              elem.product_index = IDX_W'(r*DIM + c);
              elem.product_value = product_element(r, c);
              elem.last_element  = (r*DIM + c == CELLS - 1);
              pending_products.push_back(elem);
            end
          end
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      mismatches++;
    endtask

    task check_result(mm4_out_t got);
      mm4_out_t want;
      if (pending_products.size() == 0) begin
        report_mismatch($sformatf("unexpected element index %0d value %h",
                                  got.product_index, got.product_value));
        return;
      end
      want = pending_products.pop_front();
      if (got.product_index !== want.product_index)
        report_mismatch($sformatf("product_index got %0d want %0d",
                                  got.product_index, want.product_index));
      if (got.product_value !== want.product_value)
        report_mismatch($sformatf("index %0d product_value got %h want %h",
                                  want.product_index, got.product_value,
                                  want.product_value));
      if (got.last_element !== want.last_element)
        report_mismatch($sformatf("index %0d last_element got %b want %b",
                                  want.product_index, got.last_element,
                                  want.last_element));
    endtask
  endclass

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  mm4_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  mm4_out_t out_data;

  mm4_scoreboard sb = new();
  bit            quiet = 1'b0;
  int            useful_sent = 0;
  int            cycles = 0;

  matrix_multiply_4x4_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_matrix_multiply_4x4_top NOT OK");
      $finish;
    end
  end

  // Check each result transfer, then stall the receiver at random
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_result(out_data);
      out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Present one item after an optional idle gap and hold it until the transfer
  task automatic send_item(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx,
                           logic signed [WORD_WIDTH-1:0] val);
    mm4_in_t item;
    item.action        = act;
    item.element_index = idx;
    item.element_value = val;
    if (!quiet) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    sb.note_input(item);
    if (act != ACT_UNUSED) useful_sent++;
  endtask

  // Hold the sender off until every queued product element has arrived
  task automatic wait_for_products();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_products.size() != 0);
  endtask

  // Small values keep sums in range; otherwise mix full range, small, extreme and power-of-two values
  function automatic logic signed [WORD_WIDTH-1:0] pick_value(bit small_only);
    logic signed [WORD_WIDTH-1:0] v;
    int sel;
    sel = small_only ? $urandom_range(4, 7) : $urandom_range(9);
    case (sel)
      0, 1, 2, 3: v = $urandom;
      4, 5, 6, 7: v = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      8: begin
        case ($urandom_range(3))
          0: v = ELEM_MAX;
          1: v = ELEM_MIN;
          2: v = '0;
          default: v = Q_NEG_LSB;
        endcase
      end
      default: v = $urandom_range(1) ? (32'sh1 <<< $urandom_range(30))
                                     : -(32'sh1 <<< $urandom_range(31));
    endcase
    return v;
  endfunction

  // Load every element of both matrices in shuffled order
  task automatic load_all(bit small_only);
    int order[2*CELLS];
    int j;
    int tmp;
    foreach (order[i]) order[i] = i;
    for (int i = 2*CELLS - 1; i > 0; i--) begin
      j        = $urandom_range(i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    foreach (order[i])
      send_item(order[i] < CELLS ? ACT_WR_A : ACT_WR_B,
                IDX_W'(order[i] % CELLS), pick_value(small_only));
  endtask

  initial begin
    logic signed [WORD_WIDTH-1:0] a_val;
    logic signed [WORD_WIDTH-1:0] b_val;
    int row;
    int col;
    int n;
    int kind;
    bit small_only;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: rows and columns of extremes, unit and fractional values;
    // A goes in ascending index order, B in descending order
    for (int i = 0; i < CELLS; i++) begin
      row = i / DIM;
      col = i % DIM;
      case (row)
        0: a_val = ELEM_MAX;
        1: a_val = ELEM_MIN;
        2: a_val = (col == row) ? Q_ONE : '0;
        default: a_val = col[0] ? Q_NEG_LSB : Q_ONE_P5;
      endcase
      send_item(ACT_WR_A, IDX_W'(i), a_val);
      row = (CELLS - 1 - i) / DIM;
      col = (CELLS - 1 - i) % DIM;
      case (col)
        0: b_val = ELEM_MAX;
        1: b_val = ELEM_MIN;
        2: b_val = Q_ONE;
        default: b_val = row[0] ? Q_NEG_LSB : Q_NEG_P5;
      endcase
      send_item(ACT_WR_B, IDX_W'(CELLS - 1 - i), b_val);
    end
    send_item(ACT_UNUSED, '1, ELEM_MIN);
    send_item(ACT_COMPUTE, '0, '0);
    send_item(ACT_UNUSED, '0, ELEM_MAX);
    send_item(ACT_COMPUTE, '1, Q_NEG_LSB);
    wait_for_products();

    // Random rounds: mostly full reloads, else partial updates and noise
    useful_sent = 0;
    while (useful_sent < RANDOM_ITEMS) begin
      quiet      = (useful_sent >= 120 && useful_sent < 200);
      small_only = ($urandom_range(1) == 1);
      kind       = $urandom_range(99);
      if (kind < 60) begin
        load_all(small_only);
        send_item(ACT_COMPUTE, 4'($urandom), $urandom);
      end else if (kind < 85) begin
        n = $urandom_range(1, 8);
        repeat (n)
          send_item($urandom_range(1) ? ACT_WR_A : ACT_WR_B, 4'($urandom),
                    pick_value(small_only));
        send_item(ACT_COMPUTE, 4'($urandom), $urandom);
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          send_item(ACT_UNUSED, 4'($urandom), $urandom);
          send_item($urandom_range(1) ? ACT_WR_A : ACT_WR_B, 4'($urandom),
                    pick_value(small_only));
        end
        send_item(ACT_COMPUTE, 4'($urandom), $urandom);
        if ($urandom_range(1)) send_item(ACT_COMPUTE, 4'($urandom), $urandom);
      end
      if ($urandom_range(99) < 30) wait_for_products();
    end
    quiet = 1'b0;

    // Drain and watch for stray results
    wait_for_products();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("tb_matrix_multiply_4x4_top OK");
    end else begin
      $display("tb_matrix_multiply_4x4_top NOT OK");
    end
    $finish;
  end

endmodule
